### hw/rtl/xcr_pkg.sv
// shared widths, codes and types of the xmodem crc frame receiver
`timescale 1ns / 1ps

package xcr_pkg;

	localparam int LONG_PAYLOAD  = 1024;
	localparam int SHORT_PAYLOAD = 128;
	localparam int OFF_W         = 10;
	localparam int CNT_W         = ($clog2(LONG_PAYLOAD + 1) > OFF_W) ?
	                               $clog2(LONG_PAYLOAD + 1) : OFF_W + 1;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT   = 1'd1;

	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [7:0]  RETRY_RESET   = 8'd10;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	localparam logic [1:0] REPLY_C   = 2'd0;
	localparam logic [1:0] REPLY_ACK = 2'd1;
	localparam logic [1:0] REPLY_NAK = 2'd2;

	localparam logic [2:0] VERD_NONE = 3'd0;
	localparam logic [2:0] VERD_OK   = 3'd1;
	localparam logic [2:0] VERD_CRC  = 3'd2;
	localparam logic [2:0] VERD_DUP  = 3'd3;
	localparam logic [2:0] VERD_SEQ  = 3'd4;

	localparam logic [1:0] STAT_IDLE   = 2'd0;
	localparam logic [1:0] STAT_RECV   = 2'd1;
	localparam logic [1:0] STAT_DONE   = 2'd2;
	localparam logic [1:0] STAT_CANCEL = 2'd3;

	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_STX = 8'h02;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_CAN = 8'h18;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef struct packed {
		logic             emit;
		logic             reply_valid;
		logic [1:0]       reply_code;
		logic             payload_valid;
		logic [7:0]       payload_byte;
		logic [OFF_W-1:0] payload_offset;
		logic [2:0]       frame_verdict;
		logic [7:0]       expected_block_out;
		logic [1:0]       session_status;
	} xcr_result_t;

endpackage

### hw/rtl/xcr_crc16.sv
// crc-16 (poly 0x1021) update over one byte, msb first
`timescale 1ns / 1ps

module xcr_crc16 (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);
	import xcr_pkg::*;

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

### hw/rtl/xcr_engine.sv
// session state machine: header hunt, frame checks, retries and timeout
`timescale 1ns / 1ps

module xcr_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [1:0]          kind,
	input  logic [7:0]          rx_byte,
	input  logic [15:0]         timeout_ticks,
	input  logic [7:0]          retry_limit,
	output xcr_pkg::xcr_result_t res
);
	import xcr_pkg::*;

	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_DONE   = 4'd1;
	localparam logic [3:0] PH_CANCEL = 4'd2;
	localparam logic [3:0] PH_HUNT   = 4'd3;
	localparam logic [3:0] PH_BLOCK  = 4'd4;
	localparam logic [3:0] PH_COMPL  = 4'd5;
	localparam logic [3:0] PH_DATA   = 4'd6;
	localparam logic [3:0] PH_CRCHI  = 4'd7;
	localparam logic [3:0] PH_CRCLO  = 4'd8;

	typedef struct packed {
		logic [3:0] phase;
		logic       long_frame;
		logic       ack;
	} hunt_t;

	logic [3:0]       phase_q, phase_d;
	logic [7:0]       exp_q, exp_d;
	logic             long_q, long_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [15:0]      crc_q, crc_d;
	logic [7:0]       held_q, held_d;
	logic [1:0]       class_q, class_d;
	logic [7:0]       retry_q, retry_d;
	logic [15:0]      timer_q, timer_d;
	logic [15:0]      crc_next;
	xcr_result_t      r;

	xcr_crc16 u_crc (
		.crc_in  (crc_q),
		.data    (rx_byte),
		.crc_out (crc_next)
	);

	function automatic hunt_t hunt_fn(input logic [7:0] b, input logic long_cur);
		hunt_t h;
		h.phase      = PH_HUNT;
		h.long_frame = long_cur;
		h.ack        = 1'b0;
		if (b == CH_EOT) begin
			h.phase = PH_DONE;
			h.ack   = 1'b1;
		end else if (b == CH_CAN) begin
			h.phase = PH_CANCEL;
		end else if (b == CH_SOH || b == CH_STX) begin
			h.phase      = PH_BLOCK;
			h.long_frame = (b == CH_STX);
		end
		return h;
	endfunction

	function automatic logic [1:0] status_of(input logic [3:0] ph);
		logic [1:0] s;
		unique case (ph)
			PH_IDLE:   s = STAT_IDLE;
			PH_DONE:   s = STAT_DONE;
			PH_CANCEL: s = STAT_CANCEL;
			default:   s = STAT_RECV;
		endcase
		return s;
	endfunction

	always_comb begin
		hunt_t            h0, h1;
		logic [7:0]       csum;
		logic [CNT_W-1:0] cnt_inc;
		logic [CNT_W-1:0] flen;
		logic [15:0]      t_inc;
		logic             active;
		logic             can_nak;

		phase_d = phase_q;
		exp_d   = exp_q;
		long_d  = long_q;
		count_d = count_q;
		crc_d   = crc_q;
		held_d  = held_q;
		class_d = class_q;
		retry_d = retry_q;
		timer_d = timer_q;
		r       = '0;

		active  = (phase_q >= PH_HUNT);
		can_nak = (retry_q < retry_limit);
		h0      = hunt_fn(rx_byte, long_q);
		h1      = hunt_fn(held_q, long_q);
		csum    = held_q + rx_byte;
		cnt_inc = count_q + 1'b1;
		flen    = long_q ? CNT_W'(LONG_PAYLOAD) : CNT_W'(SHORT_PAYLOAD);
		t_inc   = (timer_q == 16'hFFFF) ? timer_q : timer_q + 16'd1;

		case (kind)
			KIND_START: begin
				phase_d       = PH_HUNT;
				exp_d         = 8'd1;
				retry_d       = '0;
				timer_d       = '0;
				count_d       = '0;
				crc_d         = '0;
				r.reply_valid = 1'b1;
				r.reply_code  = REPLY_C;
			end
			KIND_BYTE: begin
				if (active) begin
					timer_d = '0;
					unique case (phase_q)
						PH_HUNT: begin
							phase_d       = h0.phase;
							long_d        = h0.long_frame;
							r.reply_valid = h0.ack;
							r.reply_code  = h0.ack ? REPLY_ACK : REPLY_C;
						end
						PH_BLOCK: begin
							held_d  = rx_byte;
							phase_d = PH_COMPL;
						end
						PH_COMPL: begin
							if (csum != 8'hFF) begin
								// bad complement: retry both held bytes as headers
								if (h1.phase == PH_BLOCK) begin
									long_d  = h1.long_frame;
									held_d  = rx_byte;
									phase_d = PH_COMPL;
								end else if (h1.phase == PH_HUNT) begin
									phase_d       = h0.phase;
									long_d        = h0.long_frame;
									r.reply_valid = h0.ack;
									r.reply_code  = h0.ack ? REPLY_ACK : REPLY_C;
								end else begin
									phase_d       = h1.phase;
									r.reply_valid = h1.ack;
									r.reply_code  = h1.ack ? REPLY_ACK : REPLY_C;
								end
							end else begin
								if (held_q == exp_q) begin
									class_d = 2'd0;
								end else if (held_q == exp_q - 8'd1) begin
									class_d = 2'd1;
								end else begin
									class_d = 2'd2;
								end
								count_d = '0;
								crc_d   = '0;
								phase_d = PH_DATA;
							end
						end
						PH_DATA: begin
							if (class_q == 2'd0) begin
								r.payload_valid  = 1'b1;
								r.payload_byte   = rx_byte;
								r.payload_offset = count_q[OFF_W-1:0];
								crc_d            = crc_next;
							end
							count_d = cnt_inc;
							if (cnt_inc >= flen) begin
								phase_d = PH_CRCHI;
							end
						end
						PH_CRCHI: begin
							held_d  = rx_byte;
							phase_d = PH_CRCLO;
						end
						PH_CRCLO: begin
							phase_d = PH_HUNT;
							if (class_q == 2'd1) begin
								r.reply_valid   = 1'b1;
								r.reply_code    = REPLY_ACK;
								r.frame_verdict = VERD_DUP;
							end else if (class_q == 2'd2 || {held_q, rx_byte} != crc_q) begin
								r.frame_verdict = (class_q == 2'd2) ? VERD_SEQ : VERD_CRC;
								if (can_nak) begin
									r.reply_valid = 1'b1;
									r.reply_code  = REPLY_NAK;
									retry_d       = retry_q + 8'd1;
								end
							end else begin
								r.reply_valid   = 1'b1;
								r.reply_code    = REPLY_ACK;
								r.frame_verdict = VERD_OK;
								exp_d           = exp_q + 8'd1;
								retry_d         = '0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			KIND_TICK: begin
				if (active) begin
					timer_d = t_inc;
					if (t_inc >= timeout_ticks && can_nak) begin
						r.reply_valid = 1'b1;
						r.reply_code  = REPLY_NAK;
						retry_d       = retry_q + 8'd1;
						timer_d       = '0;
						phase_d       = PH_HUNT;
					end
				end
			end
			default: begin
			end
		endcase

		r.expected_block_out = exp_d;
		r.session_status     = status_of(phase_d);
		r.emit = r.reply_valid | r.payload_valid | (r.frame_verdict != VERD_NONE) |
		         (status_of(phase_d) != status_of(phase_q)) |
		         (kind == KIND_BYTE && phase_q == PH_CRCLO);
	end

	assign res = r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			exp_q   <= 8'd1;
			long_q  <= 1'b0;
			count_q <= '0;
			crc_q   <= '0;
			held_q  <= '0;
			class_q <= '0;
			retry_q <= '0;
			timer_q <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			exp_q   <= exp_d;
			long_q  <= long_d;
			count_q <= count_d;
			crc_q   <= crc_d;
			held_q  <= held_d;
			class_q <= class_d;
			retry_q <= retry_d;
			timer_q <= timer_d;
		end
	end

endmodule

### hw/rtl/xmodem_crc_frame_receiver.sv
// top level of the xmodem crc frame receiver
`timescale 1ns / 1ps

// Receives an XMODEM-CRC session one request at a time on the slave stream:
// a received byte, a timer tick or a start command (s_tuser). A start sends
// 'C'; SOH opens a 128-byte frame and STX a 1024-byte frame, EOT is ACKed
// and ends the session, CAN cancels it. Payload bytes of an in-sequence
// frame appear on the master stream as they arrive and are tentative until
// the frame verdict, which comes with the last CRC byte together with the
// ACK or NAK to send back. Duplicates are ACKed, sequence and CRC errors are
// NAKed while retries last, and a tick timeout NAKs likewise. A request that
// leads to nothing gives no result. One request is taken every cycle while
// the master side does not stall; a result appears on the master stream
// after its request has passed the input register and then the output
// register, into which the state update and result decision are written.
// The output register holds a result while the master side stalls and
// then also holds off new requests. timeout_ticks and retry_limit are
// written on the cfg port, which is always ready and should only be used
// while no request is in flight.

module xmodem_crc_frame_receiver (
	input  logic                          clk,
	input  logic                          arst_n,
	// request stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
	input  logic [1:0]                    s_tuser,   // [1:0] kind
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [1:0] reply_code, [9:2] payload_byte, [19:10] payload_offset,
	// [22:20] frame_verdict, [30:23] expected_block_out,
	// [32:31] session_status, [39:33] zero
	output logic [39:0]                   m_tdata,
	output logic [1:0]                    m_tuser,   // [0] reply_valid, [1] payload_valid
	// register writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [xcr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [xcr_pkg::CFG_DAT_W-1:0] cfg_data
);
	import xcr_pkg::*;

	// configuration registers
	logic [15:0] timeout_q;
	logic [7:0]  retry_limit_q;

	// input register
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [7:0]  byte_s1;

	// output register
	logic        out_valid_q;
	xcr_result_t out_q;
	xcr_result_t res;
	logic        advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q     <= TIMEOUT_RESET;
			retry_limit_q <= RETRY_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TIMEOUT_TICKS: timeout_q     <= cfg_data[15:0];
				CFG_RETRY_LIMIT:   retry_limit_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// the held request moves on when the output register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	xcr_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (advance),
		.kind          (kind_s1),
		.rx_byte       (byte_s1),
		.timeout_ticks (timeout_q),
		.retry_limit   (retry_limit_q),
		.res           (res)
	);

	// a request with nothing to report leaves the output register empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.emit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {out_q.payload_valid, out_q.reply_valid};
	assign m_tdata  = {7'd0, out_q.session_status, out_q.expected_block_out,
	                   out_q.frame_verdict, out_q.payload_offset,
	                   out_q.payload_byte, out_q.reply_code};

endmodule

### hw/rtl/xcr_checker.sv
// port-level checks of the xmodem crc frame receiver, bound to the top level
`timescale 1ns / 1ps

module xcr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import xcr_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// no reply means a zero reply code
	a_reply_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[1:0] == REPLY_C)
		else $error("reply code without reply");

	// payload only mid-frame: no verdict, session receiving
	a_payload_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[22:20] == VERD_NONE &&
		m_tdata[32:31] == STAT_RECV)
		else $error("payload outside a frame");

	// no payload means zero byte and offset; sessions never report idle
	a_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[1] || m_tdata[19:2] == 18'd0) &&
		m_tdata[32:31] != STAT_IDLE)
		else $error("stray payload or idle status");

endmodule

bind xmodem_crc_frame_receiver xcr_checker u_xcr_checker (.*);
